// File: rtl/bsph_pkg.sv
package bsph_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } t_in;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [31:0] radius;
        logic               status;
    } t_out;

    // closed set handed from front to back: extremes in order
    // min x, max x, min y, max y, min z, max z
    typedef struct packed {
        t_point [5:0] ext;
        logic         ovf;
    } t_job;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SEED,
        ST_RD,
        ST_LOAD,
        ST_TEST,
        ST_GMUL_GO,
        ST_GMUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_NEXT,
        ST_DONE
    } t_back_state;

    function automatic logic signed [31:0] get_axis(input t_point p, input logic [1:0] a);
        logic signed [31:0] v;
        case (a)
            2'(AXIS_X): v = p.x;
            2'(AXIS_Y): v = p.y;
            default:    v = p.z;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/bsph_ram.sv
module bsph_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bsph_mul.sv
module bsph_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_a,
    input  logic [33:0] i_b,
    output logic        o_done,
    output logic [67:0] o_p
);
    logic [33:0] r_a, r_b;
    logic [67:0] r_p;
    logic [1:0]  r_step;
    logic        r_busy, r_done;
    logic [16:0] sel_a, sel_b;
    logic [33:0] pp;
    logic [67:0] pp_sh;

    // one 17x17 partial product per cycle
    assign sel_a = r_step[1] ? r_a[33:17] : r_a[16:0];
    assign sel_b = r_step[0] ? r_b[33:17] : r_b[16:0];
    assign pp    = sel_a * sel_b;

    always_comb begin
        case (r_step)
            2'd0:    pp_sh = 68'(pp);
            2'd3:    pp_sh = 68'(pp) << 34;
            default: pp_sh = 68'(pp) << 17;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= r_p + pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

// File: rtl/bsph_sqrt.sv
module bsph_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [67:0] i_x,
    output logic        o_done,
    output logic [33:0] o_root
);
    logic [67:0] r_x;
    logic [36:0] r_rem;
    logic [33:0] r_res;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [36:0] rem2, trial;

    // two radicand bits per cycle
    assign rem2  = {r_rem[34:0], r_x[67:66]};
    assign trial = {1'b0, r_res, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd33) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_rem <= '0;
            r_res <= '0;
        end else if (r_busy) begin
            r_x <= r_x << 2;
            if (rem2 >= trial) begin
                r_rem <= rem2 - trial;
                r_res <= {r_res[32:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_res <= {r_res[32:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res;
endmodule

// File: rtl/bsph_div.sv
module bsph_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [67:0] i_n,
    input  logic [33:0] i_d,
    output logic        o_done,
    output logic [33:0] o_q
);
    logic [67:0] r_n;
    logic [33:0] r_d, r_rem, r_q;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [34:0] rem2, diff;

    // restoring division, one quotient bit per cycle
    assign rem2 = {r_rem, r_n[67]};
    assign diff = rem2 - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd67) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_d   <= i_d;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_n <= r_n << 1;
            if (rem2 >= {1'b0, r_d}) begin
                r_rem <= diff[33:0];
                r_q   <= {r_q[32:0], 1'b1};
            end else begin
                r_rem <= rem2[33:0];
                r_q   <= {r_q[32:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// File: rtl/bsph_front.sv
module bsph_front #(
    parameter int MAX_POINTS = 1024,
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  bsph_pkg::t_in      i_item,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output bsph_pkg::t_point   o_ram_wdata,
    output logic               o_job_valid,
    output bsph_pkg::t_job     o_job,
    output logic [CW-1:0]      o_job_cnt,
    input  logic               i_job_pop
);
    import bsph_pkg::*;

    logic [CW-1:0]  r_cnt;
    logic           r_ovf;
    t_point [5:0]   r_ext;
    t_point [5:0]   n_ext;
    t_point         pt;
    logic           room;
    logic           r_q_valid;
    t_job           r_q_job;
    logic [CW-1:0]  r_q_cnt;

    assign pt   = '{x: i_item.point_x, y: i_item.point_y, z: i_item.point_z};
    assign room = (r_cnt < CW'(MAX_POINTS));

    // strict compares: a later point replaces an extreme only when beyond it
    always_comb begin
        n_ext = r_ext;
        if (r_cnt == '0) begin
            for (int k = 0; k < 6; k++) begin
                n_ext[k] = pt;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (get_axis(pt, 2'(k)) < get_axis(r_ext[2*k], 2'(k))) begin
                    n_ext[2*k] = pt;
                end
                if (get_axis(pt, 2'(k)) > get_axis(r_ext[2*k+1], 2'(k))) begin
                    n_ext[2*k+1] = pt;
                end
            end
        end
    end

    assign o_ram_we    = i_accept && room;
    assign o_ram_waddr = r_cnt[AW-1:0];
    assign o_ram_wdata = pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_job_pop) begin
                r_q_valid <= 1'b0;
            end
            if (i_accept) begin
                if (i_item.last_point) begin
                    r_cnt     <= '0;
                    r_ovf     <= 1'b0;
                    r_q_valid <= 1'b1;
                end else if (room) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && room) begin
            r_ext <= n_ext;
        end
        if (i_accept && i_item.last_point) begin
            r_q_job.ext <= room ? n_ext : r_ext;
            r_q_job.ovf <= r_ovf || !room;
            r_q_cnt     <= room ? r_cnt + CW'(1) : r_cnt;
        end
    end

    assign o_job_valid = r_q_valid;
    assign o_job       = r_q_job;
    assign o_job_cnt   = r_q_cnt;
endmodule

// File: rtl/bsph_back.sv
module bsph_back #(
    parameter int MAX_POINTS = 1024,
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  bsph_pkg::t_job     i_job,
    input  logic [CW-1:0]      i_job_cnt,
    output logic               o_job_pop,
    output logic               o_busy,
    output logic               o_ram_re,
    output logic [AW-1:0]      o_ram_raddr,
    input  bsph_pkg::t_point   i_ram_rdata,
    output logic               o_res_valid,
    output bsph_pkg::t_out     o_res
);
    import bsph_pkg::*;

    t_back_state    r_state, n_state;
    t_point [5:0]   r_ext;
    logic [CW-1:0]  r_cnt, r_j;
    logic           r_ovf, r_seed;
    logic [1:0]     r_pair, r_ax;
    logic [67:0]    r_acc;
    logic [33:0]    r_dist [3];
    logic [33:0]    r_len, r_r, r_num;
    t_point         r_va, r_vb, r_c;

    logic signed [32:0] diff;
    logic [32:0]        mg;
    logic               mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
    logic [33:0]        mul_b, root, quo;
    logic [67:0]        prod;
    logic [34:0]        rsum;
    logic [33:0]        rnew;
    logic [1:0]         sel;
    logic signed [34:0] cnew;
    logic signed [31:0] cclamp;

    assign diff = 33'(get_axis(r_va, r_ax)) - 33'(get_axis(r_vb, r_ax));
    assign mg   = diff[32] ? 33'(-diff) : 33'(diff);
    assign mul_b = (r_state == ST_GMUL_GO) ? r_num : {1'b0, mg};

    bsph_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a({1'b0, mg}), .i_b(mul_b), .o_done(mul_done), .o_p(prod)
    );

    bsph_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_x(r_acc), .o_done(sqrt_done), .o_root(root)
    );

    bsph_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_n(r_acc), .i_d(r_len), .o_done(div_done), .o_q(quo)
    );

    // seed pair: strict compares, ties go to the later pair
    always_comb begin
        if (r_dist[0] > r_dist[1]) begin
            sel = (r_dist[0] > r_dist[2]) ? 2'd0 : 2'd2;
        end else begin
            sel = (r_dist[1] > r_dist[2]) ? 2'd1 : 2'd2;
        end
    end

    assign rsum = {1'b0, r_r} + {1'b0, r_len};
    assign rnew = rsum[34:1];

    // move one axis of the center by the rounded-toward-zero step, clamp
    assign cnew = diff[32] ? 35'(get_axis(r_c, r_ax)) - 35'({1'b0, quo})
                           : 35'(get_axis(r_c, r_ax)) + 35'({1'b0, quo});
    always_comb begin
        if (cnew > 35'sh7FFFFFFF) begin
            cclamp = 32'sh7FFFFFFF;
        end else if (cnew < -35'sh80000000) begin
            cclamp = -32'sh80000000;
        end else begin
            cclamp = cnew[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_job_valid) n_state = ST_MUL_GO;
            ST_MUL_GO:    n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) n_state = (r_ax == 2'd2) ? ST_SQRT_GO : ST_MUL_GO;
            end
            ST_SQRT_GO:   n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    if (!r_seed)            n_state = ST_TEST;
                    else if (r_pair == 2'd2) n_state = ST_SEED;
                    else                     n_state = ST_MUL_GO;
                end
            end
            ST_SEED:      n_state = ST_RD;
            ST_RD:        n_state = ST_LOAD;
            ST_LOAD:      n_state = ST_MUL_GO;
            ST_TEST:      n_state = (r_len > r_r) ? ST_GMUL_GO : ST_NEXT;
            ST_GMUL_GO:   n_state = ST_GMUL_WAIT;
            ST_GMUL_WAIT: if (mul_done) n_state = ST_DIV_GO;
            ST_DIV_GO:    n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) n_state = (r_ax == 2'd2) ? ST_NEXT : ST_GMUL_GO;
            end
            ST_NEXT:      n_state = (r_j + CW'(1) == r_cnt) ? ST_DONE : ST_RD;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop   = (r_state == ST_IDLE) && i_job_valid;
        o_busy      = (r_state != ST_IDLE);
        mul_start   = (r_state == ST_MUL_GO) || (r_state == ST_GMUL_GO);
        sqrt_start  = (r_state == ST_SQRT_GO);
        div_start   = (r_state == ST_DIV_GO);
        o_ram_re    = (r_state == ST_RD);
        o_res_valid = (r_state == ST_DONE);
    end

    assign o_ram_raddr = r_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ext  <= i_job.ext;
                r_ovf  <= i_job.ovf;
                r_cnt  <= i_job_cnt;
                r_seed <= 1'b1;
                r_pair <= 2'd0;
                r_ax   <= 2'd0;
                r_acc  <= '0;
                r_va   <= i_job.ext[1];
                r_vb   <= i_job.ext[0];
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    r_acc <= r_acc + prod;
                    r_ax  <= r_ax + 2'd1;
                end
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    r_len <= root;
                    if (r_seed) begin
                        r_dist[r_pair] <= root;
                        r_pair <= r_pair + 2'd1;
                        r_ax   <= 2'd0;
                        r_acc  <= '0;
                        if (r_pair == 2'd0) begin
                            r_va <= r_ext[3];
                            r_vb <= r_ext[2];
                        end else begin
                            r_va <= r_ext[5];
                            r_vb <= r_ext[4];
                        end
                    end
                end
            end
            ST_SEED: begin
                r_seed <= 1'b0;
                r_j    <= '0;
                r_r    <= {1'b0, r_dist[sel][33:1]};
                r_c.x  <= 32'((33'(r_ext[2*sel].x) + 33'(r_ext[2*sel+1].x)) >>> 1);
                r_c.y  <= 32'((33'(r_ext[2*sel].y) + 33'(r_ext[2*sel+1].y)) >>> 1);
                r_c.z  <= 32'((33'(r_ext[2*sel].z) + 33'(r_ext[2*sel+1].z)) >>> 1);
            end
            ST_LOAD: begin
                r_va  <= i_ram_rdata;
                r_vb  <= r_c;
                r_ax  <= 2'd0;
                r_acc <= '0;
            end
            ST_TEST: begin
                r_r   <= (r_len > r_r) ? rnew : r_r;
                r_num <= r_len - rnew;
                r_ax  <= 2'd0;
            end
            ST_GMUL_WAIT: begin
                if (mul_done) r_acc <= prod;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (r_ax)
                        2'(AXIS_X): r_c.x <= cclamp;
                        2'(AXIS_Y): r_c.y <= cclamp;
                        default:    r_c.z <= cclamp;
                    endcase
                    r_ax <= r_ax + 2'd1;
                end
            end
            ST_NEXT: r_j <= r_j + CW'(1);
            default: ;
        endcase
    end

    always_comb begin
        o_res.center_x = r_c.x;
        o_res.center_y = r_c.y;
        o_res.center_z = r_c.z;
        o_res.radius   = (r_r[33:32] != 2'b00) ? 32'hFFFFFFFF : r_r[31:0];
        o_res.status   = r_ovf;
    end
endmodule

// File: rtl/point_cloud_bounding_sphere_core.sv
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------------
// points   | i_item (t_in)                  | word taken when start & !busy
// result   | o_result (t_out)               | o_done high one cycle, no stall
//
// Each accepted word loads one point if memory has room, else it sets status.
// The closing point hands the set to the solver, and busy stays high until the
// result word is shown. The solver measures three seed pairs (squares on a
// shared 17x17 multiplier, then a square root), then walks the stored points:
// a point inside the sphere needs its distance only, and a point that grows it
// adds three multiplies and three divisions, and the divisions dominate.
// Reset is synchronous, active low; the point memory is never cleared, only
// entries below the point count are read.
module point_cloud_bounding_sphere_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  bsph_pkg::t_in    i_item,
    output logic             o_done,
    output bsph_pkg::t_out   o_result
);
    import bsph_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic          accept;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_point        ram_wdata, ram_rdata;
    logic          job_valid, job_pop, back_busy;
    t_job          job;
    logic [CW-1:0] job_cnt;

    // hold off new words while a set waits in the queue or is being solved
    assign busy   = job_valid || back_busy;
    assign accept = start && !busy;

    bsph_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_item(i_item),
        .o_ram_we(ram_we), .o_ram_waddr(ram_waddr), .o_ram_wdata(ram_wdata),
        .o_job_valid(job_valid), .o_job(job), .o_job_cnt(job_cnt),
        .i_job_pop(job_pop)
    );

    bsph_ram #(.WIDTH($bits(t_point)), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_re(ram_re), .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    bsph_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .i_job_cnt(job_cnt), .o_job_pop(job_pop), .o_busy(back_busy),
        .o_ram_re(ram_re), .o_ram_raddr(ram_raddr), .i_ram_rdata(ram_rdata),
        .o_res_valid(o_done), .o_res(o_result)
    );
endmodule

// File: sim/point_cloud_bounding_sphere_core_tb.sv
module point_cloud_bounding_sphere_core_tb;
    import bsph_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int QUIET_LO  = 1100;   // in this window, back to back unless busy
    localparam int QUIET_HI  = 1500;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_in    i_item;
    logic   o_done;
    t_out   o_result;

    point_cloud_bounding_sphere_core #(
        .MAX_POINTS(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // ------------------------------------------------------------------
    // Predictor state: stored points, running extremes, overflow mark
    // ------------------------------------------------------------------
    longint  pt_mem [DEPTH][3];
    longint  ext_pt [6][3];       // min x, max x, min y, max y, min z, max z
    int      pt_count = 0;
    bit      pt_dropped = 1'b0;

    t_in     pending_words[$];
    t_out    sphere_fits[$];

    int      words_sent = 0;
    int      spheres_checked = 0;
    int      overflow_sets = 0;
    int      mismatches = 0;

    // floor square root of a value below 2^68
    function automatic logic [63:0] root_floor(input logic [67:0] v);
        logic [69:0] rem;
        logic [69:0] trial;
        logic [63:0] res;
        rem = '0;
        res = '0;
        for (int i = 33; i >= 0; i--) begin
            rem   = (rem << 2) | 70'(v[2*i +: 2]);
            trial = (70'(res) << 2) | 70'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                res = (res << 1) | 64'd1;
            end else begin
                res = res << 1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] span(input longint a[3], input longint b[3]);
        logic [67:0]  acc;
        logic [127:0] m;
        longint       d;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            d   = a[k] - b[k];
            m   = 128'(d < 0 ? -d : d);
            acc = acc + 68'(m * m);
        end
        return root_floor(acc);
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sh7FFFFFFF)
            return 64'sh7FFFFFFF;
        if (v < -64'sh80000000)
            return -64'sh80000000;
        return v;
    endfunction

    // seed on the farthest extreme pair, then grow around outliers
    function automatic t_out solve_sphere();
        logic [63:0]  dp[3];
        logic [63:0]  r;
        logic [63:0]  len;
        logic [63:0]  num;
        logic [127:0] q;
        longint       c[3];
        longint       p[3];
        longint       d[3];
        int           sel;
        t_out         fit;
        for (int k = 0; k < 3; k++)
            dp[k] = span(ext_pt[2*k+1], ext_pt[2*k]);
        // strict compares: ties go to the later pair
        if (dp[0] > dp[1])
            sel = dp[0] > dp[2] ? 0 : 2;
        else
            sel = dp[1] > dp[2] ? 1 : 2;
        for (int k = 0; k < 3; k++)
            c[k] = (ext_pt[2*sel][k] + ext_pt[2*sel+1][k]) >>> 1;
        r = dp[sel] >> 1;
        for (int j = 0; j < pt_count; j++) begin
            for (int k = 0; k < 3; k++)
                p[k] = pt_mem[j][k];
            len = span(p, c);
            if (len > r) begin
                for (int k = 0; k < 3; k++)
                    d[k] = p[k] - c[k];
                r   = (r + len) >> 1;
                num = len - r;
                for (int k = 0; k < 3; k++) begin
                    q    = (128'(d[k] < 0 ? -d[k] : d[k]) * 128'(num)) / 128'(len);
                    c[k] = clamp_s32(d[k] < 0 ? c[k] - longint'(q) : c[k] + longint'(q));
                end
            end
        end
        fit.center_x = 32'(c[0]);
        fit.center_y = 32'(c[1]);
        fit.center_z = 32'(c[2]);
        fit.radius   = r > 64'hFFFFFFFF ? 32'hFFFFFFFF : r[31:0];
        fit.status   = pt_dropped;
        return fit;
    endfunction

    // take one accepted word into the predictor
    task automatic load_point(input t_in w);
        longint p[3];
        p[0] = longint'(w.point_x);
        p[1] = longint'(w.point_y);
        p[2] = longint'(w.point_z);
        if (pt_count < DEPTH) begin
            for (int k = 0; k < 3; k++)
                pt_mem[pt_count][k] = p[k];
            if (pt_count == 0) begin
                for (int e = 0; e < 6; e++)
                    for (int k = 0; k < 3; k++)
                        ext_pt[e][k] = p[k];
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (p[k] < ext_pt[2*k][k])
                        for (int m = 0; m < 3; m++)
                            ext_pt[2*k][m] = p[m];
                    if (p[k] > ext_pt[2*k+1][k])
                        for (int m = 0; m < 3; m++)
                            ext_pt[2*k+1][m] = p[m];
                end
            end
            pt_count++;
        end else begin
            pt_dropped = 1'b1;
        end
        if (w.last_point) begin
            if (pt_dropped)
                overflow_sets++;
            sphere_fits.push_back(solve_sphere());
            pt_count   = 0;
            pt_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("timeout at %0t", $time);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: hold a word until busy drops, idle at random between words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            if (start && !busy) begin
                load_point(i_item);
                words_sent++;
            end
            if (!start || !busy) begin
                if (pending_words.size() != 0 &&
                    (($urandom_range(0, 99) >= 30) ||
                     (words_sent >= QUIET_LO && words_sent < QUIET_HI))) begin
                    start  <= 1'b1;
                    i_item <= pending_words.pop_front();
                end else begin
                    start  <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each shown result word against the oldest fit
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (sphere_fits.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_result);
                mismatches++;
            end else begin
                want = sphere_fits.pop_front();
                spheres_checked++;
                if (o_result.center_x !== want.center_x) begin
                    $display("%0t: center_x expected %h got %h", $time,
                             want.center_x, o_result.center_x);
                    mismatches++;
                end
                if (o_result.center_y !== want.center_y) begin
                    $display("%0t: center_y expected %h got %h", $time,
                             want.center_y, o_result.center_y);
                    mismatches++;
                end
                if (o_result.center_z !== want.center_z) begin
                    $display("%0t: center_z expected %h got %h", $time,
                             want.center_z, o_result.center_z);
                    mismatches++;
                end
                if (o_result.radius !== want.radius) begin
                    $display("%0t: radius expected %h got %h", $time,
                             want.radius, o_result.radius);
                    mismatches++;
                end
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %b got %b", $time,
                             want.status, o_result.status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_word(input longint x, input longint y, input longint z,
                            input bit last);
        t_in w;
        w.point_x    = 32'(x);
        w.point_y    = 32'(y);
        w.point_z    = 32'(z);
        w.last_point = last;
        pending_words.push_back(w);
    endtask

    // coordinate drawn from a mix of ranges: tight, moderate, full, rails
    function automatic longint pick_coord(input int mode);
        case (mode)
            0:       return longint'($urandom_range(0, 8000)) - 4000;
            1:       return longint'($signed($urandom)) >>> 12;
            2:       return longint'($signed($urandom));
            default: return $urandom_range(0, 1) ? 64'sh7FFFFFFF : -64'sh80000000;
        endcase
    endfunction

    task automatic add_set(input int n);
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
            add_word(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
        end
    endtask

    initial begin
        longint hi;
        longint lo;
        int     n;
        hi = 64'sh7FFFFFFF;
        lo = -64'sh80000000;
        i_rst_n         = 1'b0;

        // single-point sets at both rails, and at the origin
        add_word(hi, hi, hi, 1);
        add_word(lo, lo, lo, 1);
        add_word(0, 0, 0, 1);
        // opposite corners of the full range
        add_word(lo, lo, lo, 0);
        add_word(hi, hi, hi, 1);
        // all eight corners: growth far out, radius saturates
        for (int i = 0; i < 8; i++)
            add_word(i[0] ? hi : lo, i[1] ? hi : lo, i[2] ? hi : lo, i == 7);
        // equal seed pairs on x and y: y wins
        add_word(-65536, 0, 0, 0);
        add_word(65536, 0, 0, 0);
        add_word(0, -65536, 0, 0);
        add_word(0, 65536, 0, 1);
        // equal seed pairs on all axes: z wins, repeated points stay put
        add_word(0, 0, -65536, 0);
        add_word(0, 0, 65536, 0);
        add_word(-65536, 0, 0, 0);
        add_word(65536, 0, 0, 0);
        add_word(0, -65536, 0, 0);
        add_word(0, 65536, 0, 1);

        // random sets, mostly short, one past the buffer depth
        for (int s = 0; s < 140; s++) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 9);
            add_set(n);
            if (s == 60)
                add_set(DEPTH + 3);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !start && sphere_fits.size() == 0);
        repeat (400) @(posedge i_clk);

        $display("%0d point words loaded, %0d spheres checked (%0d with dropped points)",
                 words_sent, spheres_checked, overflow_sets);
        if (mismatches == 0 && sphere_fits.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d fits outstanding", mismatches, sphere_fits.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
